@@ rtl/tssc_pkg.sv @@
// Shared widths, constants and helpers of the throttle soft-start conditioner.
package tssc_pkg;

    // Field widths
    localparam int SampleW   = 10;
    localparam int NowW      = 32;
    localparam int AngleW    = 9;
    localparam int ThrW      = 8;
    localparam int CurW      = 9;
    localparam int LimitW    = 8;
    localparam int IntervalW = 16;
    localparam int SweepW    = 6;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;

    // Internal widths
    localparam int XAbsW = 9;   // |angle - 340|, at most 280
    localparam int MagW  = 15;  // |x| * gain, at most 26600
    localparam int QuoW  = 7;   // mapped magnitude, at most 95
    localparam int AbsW  = 7;   // |throttle|, at most 100
    localparam int ProdW = 15;  // |throttle| * limit, at most 25500
    localparam int CmagW = 8;   // current magnitude, at most 255

    typedef logic [SampleW-1:0]          t_sample;
    typedef logic [NowW-1:0]             t_ms;
    typedef logic [AngleW-1:0]           t_angle;
    typedef logic signed [ThrW-1:0]      t_thr;
    typedef logic signed [CurW-1:0]      t_cur;

    // Angle scaling: sample * 360 / 1024 == sample * 45 >> 7
    localparam int AngleMax = 359;
    localparam int AngleMul = 45;
    localparam int AngleSh  = 7;

    // Linear map 340 -> 60 over a span of 280
    localparam t_angle AngleFloor = 9'd60;
    localparam t_angle MapTop     = 9'd340;
    localparam logic [6:0] GainStart = 7'd85;   // 100 - 15
    localparam logic [6:0] GainRun   = 7'd95;   // 100 - 5
    localparam t_thr LoStart = 8'sd15;
    localparam t_thr LoRun   = 8'sd5;
    // floor(m / 280) == (m * 29960) >> 23 for m below 2^15
    localparam int MapRecip = 29960;
    localparam int MapSh    = 23;
    // floor(p / 100) == (p * 5243) >> 19 for p below 2^15
    localparam int PctRecip = 5243;
    localparam int PctSh    = 19;

    // Average: floor(sum / depth) by reciprocal
    localparam int AvgSh = 22;

    // Start-up sweep
    localparam logic [SweepW-1:0] SweepStart = 6'd40;
    localparam logic [SweepW-1:0] SweepEnd   = 6'd50;
    localparam t_ms StepMs = 32'd100;

    // Register indexes and reset values
    localparam logic [CfgIdxW-1:0] REG_CURRENT_LIMIT = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_WRITE_INTERVAL = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_NEUTRAL_ANGLE = 2'd2;
    localparam logic [LimitW-1:0]    RstCurrentLimit = 8'd100;
    localparam logic [IntervalW-1:0] RstWriteInterval = 16'd10;
    localparam t_angle               RstNeutralAngle = 9'd335;

    function automatic int sum_w(input int depth);
        return $clog2(AngleMax * depth + 1);
    endfunction

endpackage

@@ rtl/tssc_if.sv @@
// Item channels of the throttle soft-start conditioner: input, result, register write.
interface tssc_in_if;
    import tssc_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    reverse_switch;
    t_ms     now_ms;
    modport source(output valid, sample, reverse_switch, now_ms, input ready);
    modport sink(input valid, sample, reverse_switch, now_ms, output ready);
endinterface

interface tssc_out_if;
    import tssc_pkg::*;
    logic   valid;
    logic   ready;
    logic   send;
    t_cur   current;
    t_thr   throttle_percent;
    logic   reverse_active;
    logic   sweeping;
    t_angle avg_angle;
    modport source(output valid, send, current, throttle_percent, reverse_active,
                   sweeping, avg_angle, input ready);
    modport sink(input valid, send, current, throttle_percent, reverse_active,
                 sweeping, avg_angle, output ready);
endinterface

interface tssc_cfg_if;
    import tssc_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/tssc_cell.sv @@
// One window cell: holds one angle and passes it to its neighbor on each item.
module tssc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tssc_pkg::t_angle  i_d,
    output tssc_pkg::t_angle  o_q
);
    import tssc_pkg::*;

    t_angle r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/tssc_window.sv @@
// Sliding angle window: sample scaling, chain of cells and running sum.
module tssc_window #(
    parameter int DEPTH = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  tssc_pkg::t_sample                   i_sample,
    output logic [tssc_pkg::sum_w(DEPTH)-1:0]   o_sum
);
    import tssc_pkg::*;

    localparam int SumW = sum_w(DEPTH);
    localparam int ScW  = SampleW + 6;

    logic [ScW-1:0]  w_scaled;
    t_angle          w_tap [0:DEPTH];
    logic [SumW-1:0] r_sum;
    logic [SumW-1:0] n_sum;

    assign w_scaled = ScW'(i_sample) * ScW'(AngleMul);
    assign w_tap[0] = w_scaled[AngleSh +: AngleW];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        tssc_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_shift),
            .i_d    (w_tap[k]),
            .o_q    (w_tap[k+1])
        );
    end

    // oldest angle drops out, new one comes in
    assign n_sum = r_sum - SumW'(w_tap[DEPTH]) + SumW'(w_tap[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
endmodule

@@ rtl/throttle_soft_start_conditioner_unit.sv @@
// Throttle soft-start conditioner: one item per cycle unless output backpressure stalls
// it. Each item takes one slot in a six-stage pipeline plus the result register,
// with direction/sweep/gate state updated at the result.
// Stages stall independently, so bubbles are squeezed out under output backpressure.
// Synchronous active-low reset: window cells and sum cleared, forward, stopped,
// sweep at 40 A, time references zero, registers to their default values.
module throttle_soft_start_conditioner_unit #(
    parameter int WINDOW_DEPTH = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssc_cfg_if.sink    i_cfg,
    tssc_in_if.sink     i_in,
    tssc_out_if.source  o_out
);
    import tssc_pkg::*;

    localparam int SumW     = sum_w(WINDOW_DEPTH);
    localparam int RecipW   = AvgSh + 1;
    localparam int AvgProdW = SumW + RecipW;
    localparam logic [RecipW-1:0] AvgRecip =
        RecipW'(((2 ** AvgSh) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
    localparam int MapProdW = MagW + 15;
    localparam int PctProdW = ProdW + 13;

    // Everything an item carries down the pipeline; each stage fills in its part.
    typedef struct packed {
        logic             sw;
        t_ms              now;
        t_angle           avg;
        logic             avg_neutral;   // unclamped average above neutral
        logic             ang_neutral;   // clamped angle above neutral
        logic             xpos;          // clamped angle above 340
        logic [MagW-1:0]  m15;
        logic [MagW-1:0]  m5;
        t_thr             v15;           // forward throttle, from stop
        t_thr             v5;            // forward throttle, running
        logic [ProdW-1:0] p15;
        logic [ProdW-1:0] p5;
        t_cur             c15;           // forward current, from stop
        t_cur             c5;            // forward current, running
    } t_pipe;

    // ---------------- configuration registers ----------------
    logic [LimitW-1:0]    r_current_limit;
    logic [IntervalW-1:0] r_write_interval;
    t_angle               r_neutral_angle;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit  <= RstCurrentLimit;
            r_write_interval <= RstWriteInterval;
            r_neutral_angle  <= RstNeutralAngle;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CURRENT_LIMIT:  r_current_limit  <= i_cfg.data[LimitW-1:0];
                REG_WRITE_INTERVAL: r_write_interval <= i_cfg.data[IntervalW-1:0];
                REG_NEUTRAL_ANGLE:  r_neutral_angle  <= i_cfg.data[AngleW-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // Stage k loads whenever it is empty or its content moves on.
    logic [6:1] r_vld;
    t_pipe      r_st [1:6];
    t_pipe      n_st [1:6];
    logic [7:1] rdy;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_commit;

    always_comb begin
        rdy[7] = !r_out_valid || o_out.ready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign i_in.ready = rdy[1];
    assign w_accept   = i_in.valid && rdy[1];
    assign w_commit   = r_vld[6] && rdy[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_in.valid;
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= 6; k++) begin
            if (rdy[k]) r_st[k] <= n_st[k];
        end
    end

    // ---------------- stage 1: window update ----------------
    // The cell chain shifts on accept; its sum then belongs to the item in stage 1.
    logic [SumW-1:0] w_sum;

    tssc_window #(
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_accept),
        .i_sample(i_in.sample),
        .o_sum   (w_sum)
    );

    always_comb begin
        n_st[1]     = '0;
        n_st[1].sw  = i_in.reverse_switch;
        n_st[1].now = i_in.now_ms;
    end

    // ---------------- stage 2: average by reciprocal ----------------
    logic [AvgProdW-1:0] w_avg_prod;

    assign w_avg_prod = AvgProdW'(w_sum) * AvgProdW'(AvgRecip);

    always_comb begin
        n_st[2]     = r_st[1];
        n_st[2].avg = w_avg_prod[AvgSh +: AngleW];
    end

    // ---------------- stage 3: clamp, neutral tests, map numerators ----------------
    t_angle           w_ang;
    logic [XAbsW-1:0] w_xabs;

    always_comb begin
        w_ang  = (r_st[2].avg < AngleFloor) ? AngleFloor : r_st[2].avg;
        w_xabs = (w_ang > MapTop) ? (w_ang - MapTop) : (MapTop - w_ang);
        n_st[3]             = r_st[2];
        n_st[3].avg_neutral = r_st[2].avg > r_neutral_angle;
        n_st[3].ang_neutral = w_ang > r_neutral_angle;
        n_st[3].xpos        = w_ang > MapTop;
        n_st[3].m15         = MagW'(w_xabs) * MagW'(GainStart);
        n_st[3].m5          = MagW'(w_xabs) * MagW'(GainRun);
    end

    // ---------------- stage 4: divide by 280, add start offset ----------------
    // The sign of (angle - 340) flips the truncated quotient; reverse is the negation.
    logic [MapProdW-1:0] w_q15_prod;
    logic [MapProdW-1:0] w_q5_prod;
    t_thr                w_q15;
    t_thr                w_q5;

    assign w_q15_prod = MapProdW'(r_st[3].m15) * MapProdW'(MapRecip);
    assign w_q5_prod  = MapProdW'(r_st[3].m5) * MapProdW'(MapRecip);
    assign w_q15      = t_thr'({1'b0, w_q15_prod[MapSh +: QuoW]});
    assign w_q5       = t_thr'({1'b0, w_q5_prod[MapSh +: QuoW]});

    always_comb begin
        n_st[4]     = r_st[3];
        n_st[4].v15 = r_st[3].xpos ? (LoStart - w_q15) : (LoStart + w_q15);
        n_st[4].v5  = r_st[3].xpos ? (LoRun - w_q5) : (LoRun + w_q5);
    end

    // ---------------- stage 5: |throttle| * limit ----------------
    t_thr w_a15;
    t_thr w_a5;

    assign w_a15 = r_st[4].v15[ThrW-1] ? -r_st[4].v15 : r_st[4].v15;
    assign w_a5  = r_st[4].v5[ThrW-1] ? -r_st[4].v5 : r_st[4].v5;

    always_comb begin
        n_st[5]     = r_st[4];
        n_st[5].p15 = ProdW'(w_a15[AbsW-1:0]) * ProdW'(r_current_limit);
        n_st[5].p5  = ProdW'(w_a5[AbsW-1:0]) * ProdW'(r_current_limit);
    end

    // ---------------- stage 6: divide by 100, restore sign ----------------
    logic [PctProdW-1:0] w_c15_prod;
    logic [PctProdW-1:0] w_c5_prod;
    t_cur                w_cm15;
    t_cur                w_cm5;

    assign w_c15_prod = PctProdW'(r_st[5].p15) * PctProdW'(PctRecip);
    assign w_c5_prod  = PctProdW'(r_st[5].p5) * PctProdW'(PctRecip);
    assign w_cm15     = t_cur'({1'b0, w_c15_prod[PctSh +: CmagW]});
    assign w_cm5      = t_cur'({1'b0, w_c5_prod[PctSh +: CmagW]});

    always_comb begin
        n_st[6]     = r_st[5];
        n_st[6].c15 = r_st[5].v15[ThrW-1] ? -w_cm15 : w_cm15;
        n_st[6].c5  = r_st[5].v5[ThrW-1] ? -w_cm5 : w_cm5;
    end

    // ---------------- result stage: direction, sweep, write gate ----------------
    logic              r_dir_reverse;
    logic              r_stopped;
    logic [SweepW-1:0] r_sweep_amps;
    t_ms               r_last_step;
    t_ms               r_write_ref;

    logic              n_dir_reverse;
    logic              n_stopped;
    logic [SweepW-1:0] n_sweep_amps;
    t_ms               n_last_step;
    t_ms               n_write_ref;

    t_thr w_thr_fwd;
    t_cur w_cur_fwd;
    t_thr w_thr;
    t_cur w_cur_norm;
    t_cur w_cur;
    logic w_stop_mid;
    logic w_sweep;
    logic w_send;
    t_ms  w_step_gap;
    t_ms  w_gate_gap;

    always_comb begin
        // direction latches on the unclamped average only
        n_dir_reverse = r_st[6].avg_neutral ? !r_st[6].sw : r_dir_reverse;

        w_thr_fwd  = r_stopped ? r_st[6].v15 : r_st[6].v5;
        w_cur_fwd  = r_stopped ? r_st[6].c15 : r_st[6].c5;
        w_thr      = n_dir_reverse ? -w_thr_fwd : w_thr_fwd;
        w_cur_norm = n_dir_reverse ? -w_cur_fwd : w_cur_fwd;
        w_stop_mid = r_stopped;
        if (r_st[6].ang_neutral) begin
            // neutral: zero throttle, back to stopped
            w_thr      = '0;
            w_cur_norm = '0;
            w_stop_mid = 1'b1;
        end

        w_step_gap = r_st[6].now - r_last_step;
        w_gate_gap = r_st[6].now - r_write_ref;
        w_sweep    = w_stop_mid && (w_thr != '0) && (w_step_gap > StepMs);
        w_send     = w_gate_gap >= NowW'(r_write_interval);

        // sweep current is positive whatever the direction
        w_cur = w_sweep ? t_cur'({3'b000, r_sweep_amps}) : w_cur_norm;

        n_write_ref  = w_send ? (r_write_ref + NowW'(r_write_interval)) : r_write_ref;
        n_last_step  = r_last_step;
        n_sweep_amps = r_sweep_amps;
        n_stopped    = w_stop_mid;
        if (w_sweep) begin
            n_last_step = r_st[6].now;
            if (r_sweep_amps == SweepEnd) begin
                // last step done: running from now on
                n_sweep_amps = SweepStart;
                n_stopped    = 1'b0;
            end else begin
                n_sweep_amps = r_sweep_amps + SweepW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_reverse <= 1'b0;
            r_stopped     <= 1'b1;
            r_sweep_amps  <= SweepStart;
            r_last_step   <= '0;
            r_write_ref   <= '0;
        end else if (w_commit) begin
            r_dir_reverse <= n_dir_reverse;
            r_stopped     <= n_stopped;
            r_sweep_amps  <= n_sweep_amps;
            r_last_step   <= n_last_step;
            r_write_ref   <= n_write_ref;
        end
    end

    // ---------------- result register ----------------
    logic   r_send;
    t_cur   r_current;
    t_thr   r_throttle;
    logic   r_reverse;
    logic   r_sweeping;
    t_angle r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy[7]) begin
            r_out_valid <= r_vld[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_send     <= w_send;
            r_current  <= w_cur;
            r_throttle <= w_thr;
            r_reverse  <= n_dir_reverse;
            r_sweeping <= w_sweep;
            r_avg      <= r_st[6].avg;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.send             = r_send;
    assign o_out.current          = r_current;
    assign o_out.throttle_percent = r_throttle;
    assign o_out.reverse_active   = r_reverse;
    assign o_out.sweeping         = r_sweeping;
    assign o_out.avg_angle        = r_avg;
endmodule

@@ tb/tb_throttle_soft_start_conditioner_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the throttle soft-start conditioner unit.
module tb_throttle_soft_start_conditioner_unit;
    import tssc_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int RstCycles   = 11;
    localparam int WinDepth    = 50;
    localparam int MaxGap      = 6;     // longest idle draw on either side
    localparam int IdleLimit   = 1000;  // cycles with no item moving anywhere
    localparam int DrainCycles = 20;    // idle wait at the end, longer than the pipeline latency
    localparam int MaxReports  = 10;
    localparam int RandPhases  = 5;
    localparam int PhaseItems  = 120;
    localparam int SampleMax   = 1023;
    // Index past the end of the register list: the block must ignore it.
    localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;

    typedef struct {
        t_sample sample;
        logic    rev_sw;
        t_ms     now_ms;
    } t_throttle_item;

    typedef struct packed {
        logic   send;
        t_cur   current;
        t_thr   throttle_percent;
        logic   reverse_active;
        logic   sweeping;
        t_angle avg_angle;
    } t_motor_cmd;

    logic i_clk;
    logic i_rst_n;

    tssc_in_if  in_ch();
    tssc_out_if res_ch();
    tssc_cfg_if cfg_ch();

    throttle_soft_start_conditioner_unit #(
        .WINDOW_DEPTH(WinDepth)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (res_ch)
    );

    initial i_clk = 1'b0;
    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and of the conditioner state
    // ------------------------------------------------------------------
    logic [LimitW-1:0]    lim_amps;
    logic [IntervalW-1:0] gap_ms;
    t_angle               neutral_deg;

    t_angle      angle_ring [WinDepth];
    int unsigned angle_sum;
    int          ring_idx;
    logic        dir_rev;
    logic        is_stopped;
    int          sweep_a;
    t_ms         last_step;
    t_ms         write_ref;

    function automatic void reset_conditioner();
        lim_amps    = RstCurrentLimit;
        gap_ms      = RstWriteInterval;
        neutral_deg = RstNeutralAngle;
        foreach (angle_ring[k]) angle_ring[k] = '0;
        angle_sum  = 0;
        ring_idx   = 0;
        dir_rev    = 1'b0;
        is_stopped = 1'b1;
        sweep_a    = 40;
        last_step  = '0;
        write_ref  = '0;
    endfunction

    // One item in, one motor command out; updates the predictor state.
    function automatic t_motor_cmd condition_throttle(t_throttle_item it);
        t_motor_cmd  r;
        int unsigned avg;
        int          ang;
        int          lo;
        int          hi;
        int          thr;
        int          cur;
        logic        sweep;
        t_ms         dt;
        // window average of the scaled angle
        angle_sum -= angle_ring[ring_idx];
        angle_ring[ring_idx] = t_angle'((int'(it.sample) * 360) / 1024);
        angle_sum += angle_ring[ring_idx];
        ring_idx = (ring_idx + 1) % WinDepth;
        avg = angle_sum / WinDepth;
        // direction latches on the raw average only
        if (avg > neutral_deg) dir_rev = (it.rev_sw == 1'b0);
        ang = (avg < 60) ? 60 : int'(avg);
        if (dir_rev) begin
            lo = is_stopped ? -15 : -5;
            hi = -100;
        end else begin
            lo = is_stopped ? 15 : 5;
            hi = 100;
        end
        // SV division truncates toward zero, tiny opposite-sign values survive
        thr = (ang - 340) * (hi - lo) / (60 - 340) + lo;
        if (ang > neutral_deg) begin
            thr = 0;
            is_stopped = 1'b1;
        end
        sweep = 1'b0;
        dt = it.now_ms - last_step;
        if (is_stopped && thr != 0 && dt > 100) begin
            // start-up sweep: positive in both directions
            sweep = 1'b1;
            last_step = it.now_ms;
            cur = sweep_a;
            sweep_a++;
            if (sweep_a > 50) begin
                is_stopped = 1'b0;
                sweep_a = 40;
            end
        end else begin
            cur = thr * int'(lim_amps) / 100;
        end
        // write gate, reference steps by the interval
        dt = it.now_ms - write_ref;
        r.send = (dt >= t_ms'(gap_ms));
        if (r.send) write_ref += t_ms'(gap_ms);
        r.current          = t_cur'(cur);
        r.throttle_percent = t_thr'(thr);
        r.reverse_active   = dir_rev;
        r.sweeping         = sweep;
        r.avg_angle        = t_angle'(avg);
        return r;
    endfunction

    function automatic string cmd_str(t_motor_cmd c);
        return $sformatf("send=%0b cur=%0d thr=%0d rev=%0b sweep=%0b avg=%0d",
                         c.send, c.current, c.throttle_percent, c.reverse_active,
                         c.sweeping, c.avg_angle);
    endfunction

    // ------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------
    t_throttle_item pending_items [$];
    t_motor_cmd     expected_cmds [$];

    int  n_in_drv    = 0;  // items put on the input channel
    int  n_in_acc    = 0;  // items taken by the block
    int  n_out_acc   = 0;  // results taken from the block
    int  n_bad       = 0;
    int  idle_cycles = 0;
    int  in_wait     = 0;
    bit  in_burst    = 1'b0;
    int  out_seen    = 0;
    int  out_wait    = 0;
    bit  out_burst   = 1'b0;
    t_ms clock_ms;

    // ------------------------------------------------------------------
    // Input driver: one item per handshake, random gap after each item.
    // Valid is touched once per falling edge, so a back-to-back item keeps
    // it high rather than dropping and raising it.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_throttle_item it;
        if (!(in_ch.valid && n_in_acc != n_in_drv)) begin
            if (in_wait > 0) begin
                in_wait--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                in_ch.sample         <= it.sample;
                in_ch.reverse_switch <= it.rev_sw;
                in_ch.now_ms         <= it.now_ms;
                in_ch.valid          <= 1'b1;
                n_in_drv++;
                // occasional stretches with no idling at all
                if ($urandom_range(0, 99) < 4) in_burst = !in_burst;
                in_wait = in_burst ? 0 : $urandom_range(0, MaxGap);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Accepted item: run the predictor and queue the expected command.
    always @(posedge i_clk) begin
        t_throttle_item it;
        if (in_ch.valid && in_ch.ready) begin
            it.sample = in_ch.sample;
            it.rev_sw = in_ch.reverse_switch;
            it.now_ms = in_ch.now_ms;
            expected_cmds.push_back(condition_throttle(it));
            n_in_acc++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall after each result, then compare in order
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (n_out_acc != out_seen) begin
            out_seen = n_out_acc;
            if ($urandom_range(0, 99) < 4) out_burst = !out_burst;
            out_wait = out_burst ? 0 : $urandom_range(0, MaxGap);
        end
        if (out_wait > 0) begin
            out_wait--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_motor_cmd got;
        t_motor_cmd want;
        if (res_ch.valid && res_ch.ready) begin
            n_out_acc++;
            got.send             = res_ch.send;
            got.current          = res_ch.current;
            got.throttle_percent = res_ch.throttle_percent;
            got.reverse_active   = res_ch.reverse_active;
            got.sweeping         = res_ch.sweeping;
            got.avg_angle        = res_ch.avg_angle;
            if (expected_cmds.size() == 0) begin
                n_bad++;
                if (n_bad <= MaxReports)
                    $display("result %0d: none expected, got %s", n_out_acc, cmd_str(got));
            end else begin
                want = expected_cmds.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= MaxReports)
                        $display("result %0d: expected %s, got %s",
                                 n_out_acc, cmd_str(want), cmd_str(got));
                end
            end
        end
    end

    // Watchdog: no item moving on any channel for too long ends the run.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout: no item moved for %0d cycles", IdleLimit);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input int s, input logic sw, input t_ms now);
        pending_items.push_back('{t_sample'(s), sw, now});
    endtask

    // Register write; the predictor copy follows at the same handshake.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_CURRENT_LIMIT:  lim_amps    = d[LimitW-1:0];
            REG_WRITE_INTERVAL: gap_ms      = d;
            REG_NEUTRAL_ANGLE:  neutral_deg = d[AngleW-1:0];
            default: ;
        endcase
    endtask

    // All three registers, junk in the bits above each register's width.
    task automatic set_regs(input int lim, input int gap, input int neu);
        write_reg(REG_CURRENT_LIMIT, 16'(lim) | (16'($urandom) & 16'hFF00));
        write_reg(REG_WRITE_INTERVAL, 16'(gap));
        write_reg(REG_NEUTRAL_ANGLE, 16'(neu) | (16'($urandom) & 16'hFE00));
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Idle: nothing left to send, nothing in flight, every result back.
    task automatic wait_idle();
        while (pending_items.size() != 0 || n_in_drv != n_in_acc || in_ch.valid ||
               expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // Random part: segments that hold a throttle level long enough to move
    // the 50-deep average, with jitter, switch chatter and a timing style
    // per segment (fast, sweep-paced, mixed, rare large jumps).
    task automatic queue_run(input int n_items);
        int   level;
        int   hold;
        int   mode;
        int   s;
        logic sw;
        t_ms  dt;
        while (n_items > 0) begin
            hold = $urandom_range(5, 70);
            sw   = 1'($urandom_range(0, 1));
            mode = $urandom_range(0, 3);
            case ($urandom_range(0, 5))
                0: level = $urandom_range(960, SampleMax);    // resting in neutral
                1: level = $urandom_range(0, 170);            // full throttle
                2: level = (int'(neutral_deg) * 1024) / 360   // near neutral edge
                           + int'($urandom_range(0, 10)) - 5;
                3: level = $urandom_range(1010, SampleMax);   // tiny running throttle
                4: level = -1;                                // pure noise
                default: level = $urandom_range(0, SampleMax);
            endcase
            if ($urandom_range(0, 19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            for (int k = 0; k < hold && n_items > 0; k++) begin
                if (level < 0) s = $urandom_range(0, SampleMax);
                else s = level + int'($urandom_range(0, 16)) - 8;
                if (s < 0) s = 0;
                else if (s > SampleMax) s = SampleMax;
                if ($urandom_range(0, 9) == 0) sw = ~sw;
                case (mode)
                    0: dt = $urandom_range(0, 15);
                    1: dt = $urandom_range(95, 130);
                    2: dt = $urandom_range(0, 200);
                    default: dt = ($urandom_range(0, 49) == 0) ? t_ms'($urandom)
                                                                : $urandom_range(0, 60);
                endcase
                clock_ms += dt;
                queue_item(s, sw, clock_ms);
                n_items--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.reverse_switch = 1'b0;
        in_ch.now_ms         = '0;
        res_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_CURRENT_LIMIT;
        cfg_ch.data          = '0;
        reset_conditioner();
        repeat (RstCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: field extremes, time wrap, first sweep steps
        // (empty window reads as full throttle).
        queue_item(0, 1'b1, 32'd0);
        queue_item(SampleMax, 1'b0, 32'd5);
        queue_item(SampleMax, 1'b1, 32'd101);
        queue_item(512, 1'b0, 32'd250);
        queue_item(0, 1'b1, 32'hFFFF_FFF0);
        queue_item(SampleMax, 1'b0, 32'hFFFF_FFFF);
        queue_item(0, 1'b1, 32'd60);
        queue_item(300, 1'b1, 32'd180);
        wait_idle();

        // Neutral at zero: any nonzero average latches the switch, so reverse
        // latches at once; zero interval sends every command; unused index.
        set_regs(255, 0, 0);
        write_reg(REG_NONE, 16'hFFFF);
        close_writes();
        queue_item(SampleMax, 1'b0, 32'd400);
        queue_item(SampleMax, 1'b1, 32'd402);
        queue_item(0, 1'b0, 32'd410);
        wait_idle();

        // Neutral at 359 never matches the average: reverse stays, sweep runs
        // with positive current, gap of exactly 100 ms takes no step.
        set_regs(0, 65535, 359);
        close_writes();
        queue_item(0, 1'b1, 32'd600);
        queue_item(0, 1'b1, 32'd700);
        for (int k = 0; k < 6; k++) queue_item(0, 1'b1, 32'd801 + 32'(101 * k));
        wait_idle();

        // Random phases, each under its own register setting.
        clock_ms = 32'd2000;
        for (int ph = 0; ph < RandPhases; ph++) begin
            case (ph)
                0: set_regs(255, 1, 335);
                1: set_regs(0, 65535, 359);
                2: set_regs($urandom_range(0, 255), $urandom_range(1, 40),
                            $urandom_range(250, 359));
                3: set_regs(100, 0, 511);   // neutral above 359: never neutral
                default: set_regs($urandom_range(0, 255), $urandom_range(1, 200),
                                  $urandom_range(300, 359));
            endcase
            close_writes();
            queue_run(PhaseItems);
            wait_idle();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tssc_pkg.sv
rtl/tssc_if.sv
rtl/tssc_cell.sv
rtl/tssc_window.sv
rtl/throttle_soft_start_conditioner_unit.sv
tb/tb_throttle_soft_start_conditioner_unit.sv
